// ===== rtl/rhsv_pkg.sv =====
`default_nettype none
package rhsv_pkg;

  localparam int CH_W = 8;                 // pixel channel width
  localparam int Q_W = 8;                  // quotient (hue / sat) width
  localparam int HNUM_W = 19;              // 255 * n, n < 1530
  localparam int HDIV_W = 11;              // 6 * d, up to 1530
  localparam int SNUM_W = 16;              // 255 * d
  localparam int SDIV_W = 8;               // max channel
  localparam int BITS_PER_STAGE = 2;       // quotient bits resolved per stage
  localparam int DIV_STAGES = Q_W / BITS_PER_STAGE;

  // sector of the largest channel
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  // payload carried through the divider stages
  typedef struct packed {
    logic [HNUM_W-1:0] h_rem;
    logic [HDIV_W-1:0] h_div;
    logic [Q_W-1:0]    h_q;
    logic              h_zero;   // grey pixel: hue forced to 0
    logic [SNUM_W-1:0] s_rem;
    logic [SDIV_W-1:0] s_div;
    logic [Q_W-1:0]    s_q;
    logic              s_zero;   // black pixel: sat forced to 0
    logic [CH_W-1:0]   val;
  } div_t;

endpackage
`default_nettype wire

// ===== rtl/rhsv_if.sv =====
`default_nettype none
interface rhsv_pix_if;
  logic                      valid;
  logic                      ready;
  logic [rhsv_pkg::CH_W-1:0] red_in;
  logic [rhsv_pkg::CH_W-1:0] green_in;
  logic [rhsv_pkg::CH_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface rhsv_hsv_if;
  logic                     valid;
  logic                     ready;
  logic [rhsv_pkg::Q_W-1:0] hue_out;
  logic [rhsv_pkg::Q_W-1:0] sat_out;
  logic [rhsv_pkg::CH_W-1:0] val_out;

  modport source (output valid, output hue_out, output sat_out, output val_out,
                  input ready);
  modport sink   (input valid, input hue_out, input sat_out, input val_out,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/rgb_to_hsv_8bit_top.sv =====
`default_nettype none
// RGB to HSV converter, 8 bits per channel.
//
// in_pix  : request carries red_in, green_in, blue_in; taken on valid && ready.
// out_hsv : request carries hue_out, sat_out, val_out; taken on valid && ready.
// val_out is the largest channel, sat_out = floor(255*(max-min)/max),
// hue_out = floor(255*N/(6*(max-min))) with N from the winning sector
// (red beats green beats blue on ties). Grey pixels give hue 0, sat 0.
//
// Pipeline: 2 front stages, then 4 restoring-divide stages of 2 quotient bits
// each, the hue and sat divides running side by side.
// Throughput: one pixel per clock while out_hsv.ready is held high.
//
// Each stage has its own valid bit and takes a new request whenever it is
// empty or its successor moves, so bubbles close up under backpressure and
// the input keeps accepting while a finished result waits in the output
// register. With out_hsv.ready low and all six stages full, in_pix.ready
// drops; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
module rgb_to_hsv_8bit_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rhsv_pix_if.sink    in_pix,
  rhsv_hsv_if.source  out_hsv
);

  localparam int NS = rhsv_pkg::DIV_STAGES;

  logic           stg_valid [0:NS];
  logic           stg_ready [0:NS];
  rhsv_pkg::div_t stg_data  [0:NS];
  rhsv_pkg::div_t last;

  // front end: sector detect and numerator/divisor setup
  rhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix      (in_pix),
    .dn_valid (stg_valid[0]),
    .dn_ready (stg_ready[0]),
    .dn_data  (stg_data[0])
  );

  // divider chain, quotient MSB first
  for (genvar i = 0; i < NS; i++) begin : g_div
    rhsv_div_stage #(
      .HI_BIT (rhsv_pkg::Q_W - 1 - i * rhsv_pkg::BITS_PER_STAGE)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[i]),
      .up_ready (stg_ready[i]),
      .up_data  (stg_data[i]),
      .dn_valid (stg_valid[i+1]),
      .dn_ready (stg_ready[i+1]),
      .dn_data  (stg_data[i+1])
    );
  end

  assign last              = stg_data[NS];
  assign stg_ready[NS]     = out_hsv.ready;
  assign out_hsv.valid     = stg_valid[NS];
  // zero divisor cases: forced results
  assign out_hsv.hue_out   = last.h_zero ? '0 : last.h_q;
  assign out_hsv.sat_out   = last.s_zero ? '0 : last.s_q;
  assign out_hsv.val_out   = last.val;

  // zero saturation only for grey pixels, where hue is zero too
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_hsv.valid && out_hsv.sat_out == '0) |-> (out_hsv.hue_out == '0))
    else $error("nonzero hue with zero saturation");

  // hue never reaches the full circle
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_hsv.valid |-> (out_hsv.hue_out != 8'hFF))
    else $error("hue out of range");

  // input stalls only when the whole pipe is full and the output is held
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> (!out_hsv.ready && stg_valid[0] && stg_valid[NS]))
    else $error("input stalled with room in the pipe");

  // black pixel has zero saturation
  a_sat_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_hsv.valid && out_hsv.val_out == '0) |-> (out_hsv.sat_out == '0))
    else $error("nonzero saturation for black pixel");

endmodule
`default_nettype wire

// ===== rtl/rhsv_front.sv =====
`default_nettype none
// Two stages: max/min/sector, then numerators and divisors for both divides.
module rhsv_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  rhsv_pix_if.sink            pix,
  output logic                dn_valid,
  input  wire logic           dn_ready,
  output rhsv_pkg::div_t      dn_data
);

  logic                      v1_r, v2_r;
  logic                      rdy1, rdy2;
  logic [rhsv_pkg::CH_W-1:0] r1_r, g1_r, b1_r, mx1_r, mn1_r;
  logic [1:0]                sec1_r;
  rhsv_pkg::div_t            d2_r;

  logic [rhsv_pkg::CH_W-1:0] mx_nxt, mn_nxt;
  logic [1:0]                sec_nxt;
  rhsv_pkg::div_t            d2_nxt;

  logic [rhsv_pkg::CH_W-1:0]   dif;
  logic [rhsv_pkg::HDIV_W-1:0] six_d;
  logic signed [11:0]          n_s;
  logic signed [11:0]          n_w;
  logic [rhsv_pkg::HDIV_W-1:0] n_u;

  assign rdy2 = !v2_r || dn_ready;
  assign rdy1 = !v1_r || rdy2;
  assign pix.ready = rdy1;

  // stage 1: largest, smallest, winning sector (red, then green, then blue)
  always_comb begin
    mx_nxt = pix.red_in;
    mn_nxt = pix.red_in;
    if (pix.green_in > mx_nxt) mx_nxt = pix.green_in;
    if (pix.blue_in > mx_nxt)  mx_nxt = pix.blue_in;
    if (pix.green_in < mn_nxt) mn_nxt = pix.green_in;
    if (pix.blue_in < mn_nxt)  mn_nxt = pix.blue_in;
    if (pix.red_in == mx_nxt)        sec_nxt = rhsv_pkg::SEC_RED;
    else if (pix.green_in == mx_nxt) sec_nxt = rhsv_pkg::SEC_GREEN;
    else                             sec_nxt = rhsv_pkg::SEC_BLUE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= pix.valid;
    end
    if (rdy1 && pix.valid) begin
      r1_r   <= pix.red_in;
      g1_r   <= pix.green_in;
      b1_r   <= pix.blue_in;
      mx1_r  <= mx_nxt;
      mn1_r  <= mn_nxt;
      sec1_r <= sec_nxt;
    end
  end

  // stage 2: hue numerator 255*n over 6d, sat numerator 255*d over max
  always_comb begin
    dif   = mx1_r - mn1_r;
    six_d = rhsv_pkg::HDIV_W'({dif, 2'b00}) + rhsv_pkg::HDIV_W'({dif, 1'b0});
    case (sec1_r)
      rhsv_pkg::SEC_RED:
        n_s = $signed({4'b0, g1_r}) - $signed({4'b0, b1_r});
      rhsv_pkg::SEC_GREEN:
        n_s = $signed({3'b0, dif, 1'b0}) + $signed({4'b0, b1_r})
              - $signed({4'b0, r1_r});
      default:
        n_s = $signed({2'b0, dif, 2'b00}) + $signed({4'b0, r1_r})
              - $signed({4'b0, g1_r});
    endcase
    n_w = (n_s < 0) ? (n_s + $signed({1'b0, six_d})) : n_s;
    n_u = n_w[rhsv_pkg::HDIV_W-1:0];

    d2_nxt.h_rem  = {n_u, 8'b0} - rhsv_pkg::HNUM_W'(n_u);
    d2_nxt.h_div  = six_d;
    d2_nxt.h_q    = '0;
    d2_nxt.h_zero = (dif == '0);
    d2_nxt.s_rem  = {dif, 8'b0} - rhsv_pkg::SNUM_W'(dif);
    d2_nxt.s_div  = mx1_r;
    d2_nxt.s_q    = '0;
    d2_nxt.s_zero = (mx1_r == '0);
    d2_nxt.val    = mx1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2 && v1_r) begin
      d2_r <= d2_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_data  = d2_r;

endmodule
`default_nettype wire

// ===== rtl/rhsv_div_stage.sv =====
`default_nettype none
// Resolves BITS_PER_STAGE quotient bits of both divides, top bit HI_BIT.
module rhsv_div_stage #(
  parameter int HI_BIT = rhsv_pkg::Q_W - 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           up_valid,
  output logic                up_ready,
  input  wire rhsv_pkg::div_t up_data,
  output logic                dn_valid,
  input  wire logic           dn_ready,
  output rhsv_pkg::div_t      dn_data
);

  logic           v_r;
  rhsv_pkg::div_t d_r;
  rhsv_pkg::div_t d_nxt;

  assign up_ready = !v_r || dn_ready;

  always_comb begin
    logic [rhsv_pkg::HNUM_W-1:0] h_try;
    logic [rhsv_pkg::SNUM_W-1:0] s_try;
    d_nxt = up_data;
    for (int j = 0; j < rhsv_pkg::BITS_PER_STAGE; j++) begin
      h_try = rhsv_pkg::HNUM_W'(up_data.h_div) << (HI_BIT - j);
      s_try = rhsv_pkg::SNUM_W'(up_data.s_div) << (HI_BIT - j);
      if (d_nxt.h_rem >= h_try) begin
        d_nxt.h_rem = d_nxt.h_rem - h_try;
        d_nxt.h_q[HI_BIT-j] = 1'b1;
      end
      if (d_nxt.s_rem >= s_try) begin
        d_nxt.s_rem = d_nxt.s_rem - s_try;
        d_nxt.s_q[HI_BIT-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule
`default_nettype wire

// ===== bench/rgb_to_hsv_8bit_top_tb.sv =====
`default_nettype none
module rgb_to_hsv_8bit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_STALL   = 80;      // long output hold-off, in cycles
  localparam int STALL_AT     = 300;     // pixels taken before the long hold-off
  localparam int TAIL_ITEMS   = 200;     // last pixels run with no idling at all
  localparam int DRAIN_CYCLES = 12;      // drain wait after the last result; pipeline is 6 deep
  localparam int LIMIT_CYCLES = 200000;  // watchdog limit for the whole run
  localparam int MAX_SHOWN    = 10;

  typedef struct packed {
    logic [rhsv_pkg::CH_W-1:0] red;
    logic [rhsv_pkg::CH_W-1:0] green;
    logic [rhsv_pkg::CH_W-1:0] blue;
    bit                        drain_first;  // hold this pixel until the pipe is empty
  } pixel_req_t;

  typedef struct packed {
    logic [rhsv_pkg::CH_W-1:0] red;
    logic [rhsv_pkg::CH_W-1:0] green;
    logic [rhsv_pkg::CH_W-1:0] blue;
    logic [rhsv_pkg::Q_W-1:0]  hue;
    logic [rhsv_pkg::Q_W-1:0]  sat;
    logic [rhsv_pkg::CH_W-1:0] val;
  } hsv_exp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rhsv_pix_if pix ();
  rhsv_hsv_if hsv ();

  rgb_to_hsv_8bit_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix),
    .out_hsv (hsv)
  );

  always #2 clk = ~clk;

  pixel_req_t pixel_q[$];     // pixels waiting to be offered
  hsv_exp_t   hsv_exp_q[$];   // conversions owed by the block, oldest first
  int         n_pixels = 0;   // total pixels queued by the stimulus
  int         n_taken = 0;    // pixels accepted by the block
  int         n_bad = 0;
  int         n_cycles = 0;
  bit         pix_took = 1'b0;
  int         send_gap = 0;
  int         recv_gap = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  // Exact integer RGB -> HSV. Ties on the max channel go red, then green, then blue.
  function automatic hsv_exp_t rgb2hsv_predict(input logic [rhsv_pkg::CH_W-1:0] r,
                                               input logic [rhsv_pkg::CH_W-1:0] g,
                                               input logic [rhsv_pkg::CH_W-1:0] b);
    int ri, gi, bi, hi, lo, span, num;
    hsv_exp_t res;
    ri = r;
    gi = g;
    bi = b;
    hi = ri;
    lo = ri;
    if (gi > hi) hi = gi;
    if (bi > hi) hi = bi;
    if (gi < lo) lo = gi;
    if (bi < lo) lo = bi;
    span = hi - lo;
    res.red = r;
    res.green = g;
    res.blue = b;
    res.val = hi[rhsv_pkg::CH_W-1:0];
    res.sat = (hi != 0) ? rhsv_pkg::Q_W'((255 * span) / hi) : '0;
    res.hue = '0;
    if (span != 0) begin
      if (ri == hi) num = gi - bi;
      else if (gi == hi) num = 2 * span + (bi - ri);
      else num = 4 * span + (ri - gi);
      if (num < 0) num += 6 * span;   // wrap around the circle
      res.hue = rhsv_pkg::Q_W'((num * 255) / (6 * span));
    end
    return res;
  endfunction

  function automatic void queue_pixel(input int r, input int g, input int b,
                                      input bit drain);
    pixel_req_t p;
    p.red = r[rhsv_pkg::CH_W-1:0];
    p.green = g[rhsv_pkg::CH_W-1:0];
    p.blue = b[rhsv_pkg::CH_W-1:0];
    p.drain_first = drain;
    pixel_q.push_back(p);
    n_pixels++;
  endfunction

  function automatic int clamp8(input int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  // Quiet tail: no idling on either side once the last pixels are being sent.
  function automatic bit in_tail();
    return n_taken >= n_pixels - TAIL_ITEMS;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: changes inputs on the falling edge. A request stays up until it is
  // taken; after a taken pixel it may start a random idle burst.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    pixel_req_t nxt;
    bit around_hold;
    if (!rst_n) begin
      pix.valid <= 1'b0;
    end else if (!pix.valid || pix_took) begin
      pix_took = 1'b0;
      // keep offering through the long output hold-off so the pipe fills up
      around_hold = (n_taken >= STALL_AT - 10) && (n_taken < STALL_AT + 40);
      if (send_gap > 0) begin
        send_gap--;
        pix.valid <= 1'b0;
      end else if (pixel_q.size() == 0 ||
                   (pixel_q[0].drain_first && hsv_exp_q.size() != 0)) begin
        pix.valid <= 1'b0;
      end else begin
        nxt = pixel_q.pop_front();
        pix.valid <= 1'b1;
        pix.red_in <= nxt.red;
        pix.green_in <= nxt.green;
        pix.blue_in <= nxt.blue;
        if (!in_tail() && !around_hold && $urandom_range(0, 9) == 0)
          send_gap = $urandom_range(1, 15);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side backpressure: random bursts, one long hold-off of its own.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      hsv.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      hsv.ready <= 1'b0;
    end else if (!hold_done && n_taken >= STALL_AT) begin
      hold_done = 1'b1;
      hold_left = LONG_STALL - 1;
      hsv.ready <= 1'b0;
    end else if (in_tail()) begin
      hsv.ready <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      hsv.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(1, 15) - 1;
      hsv.ready <= 1'b0;
    end else begin
      hsv.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge. Taken pixels become
  // expectations; taken results are checked against the oldest one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    hsv_exp_t want;
    if (rst_n) begin
      if (pix.valid && pix.ready) begin
        hsv_exp_q.push_back(rgb2hsv_predict(pix.red_in, pix.green_in, pix.blue_in));
        n_taken++;
        pix_took = 1'b1;
      end
      if (hsv.valid && hsv.ready) begin
        if (hsv_exp_q.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_SHOWN)
            $display("%0t: unexpected result hue=%0d sat=%0d val=%0d", $realtime,
                     hsv.hue_out, hsv.sat_out, hsv.val_out);
        end else begin
          want = hsv_exp_q.pop_front();
          if (hsv.hue_out !== want.hue || hsv.sat_out !== want.sat ||
              hsv.val_out !== want.val) begin
            n_bad++;
            if (n_bad <= MAX_SHOWN)
              $display("%0t: rgb=(%0d,%0d,%0d) expected hsv=(%0d,%0d,%0d) got (%0d,%0d,%0d)",
                       $realtime, want.red, want.green, want.blue,
                       want.hue, want.sat, want.val,
                       hsv.hue_out, hsv.sat_out, hsv.val_out);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int base, mode, ch;
    int extremes[4];
    int trio[3];
    extremes = '{0, 1, 254, 255};
    pix.valid = 1'b0;
    pix.red_in = '0;
    pix.green_in = '0;
    pix.blue_in = '0;
    hsv.ready = 1'b0;

    // directed corners
    queue_pixel(0, 0, 0, 1'b0);        // black: no sat, no hue
    queue_pixel(255, 255, 255, 1'b0);  // white
    queue_pixel(128, 128, 128, 1'b0);  // mid grey
    queue_pixel(255, 0, 0, 1'b0);      // pure primaries
    queue_pixel(0, 255, 0, 1'b0);
    queue_pixel(0, 0, 255, 1'b0);
    queue_pixel(255, 255, 0, 1'b0);    // red/green tie goes red
    queue_pixel(0, 255, 255, 1'b0);    // green/blue tie goes green
    queue_pixel(255, 0, 255, 1'b0);    // red/blue tie goes red
    queue_pixel(255, 0, 1, 1'b0);      // red sector, negative hue wraps
    queue_pixel(255, 0, 254, 1'b0);
    queue_pixel(1, 0, 0, 1'b0);        // smallest nonzero span
    queue_pixel(0, 0, 1, 1'b0);
    queue_pixel(1, 1, 0, 1'b0);
    queue_pixel(0, 1, 1, 1'b0);
    queue_pixel(1, 0, 1, 1'b0);
    queue_pixel(255, 254, 0, 1'b0);
    queue_pixel(0, 1, 255, 1'b0);
    queue_pixel(254, 0, 255, 1'b0);
    queue_pixel(255, 255, 254, 1'b0);  // tiny span at full value
    queue_pixel(170, 85, 255, 1'b0);
    queue_pixel(85, 255, 170, 1'b0);

    // random pixels, weighted toward grey-ish, tied and extreme values
    for (int i = 0; i < 900; i++) begin
      mode = $urandom_range(0, 9);
      if (mode <= 4) begin
        trio[0] = $urandom_range(0, 255);
        trio[1] = $urandom_range(0, 255);
        trio[2] = $urandom_range(0, 255);
      end else if (mode <= 6) begin
        base = $urandom_range(0, 255);
        for (int k = 0; k < 3; k++)
          trio[k] = clamp8(base + $urandom_range(0, 6) - 3);
      end else if (mode == 7) begin
        base = $urandom_range(0, 255);
        ch = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++)
          trio[k] = (k == ch) ? $urandom_range(0, 255) : base;
      end else if (mode == 8) begin
        for (int k = 0; k < 3; k++)
          trio[k] = extremes[$urandom_range(0, 3)];
      end else begin
        base = $urandom_range(0, 255);
        trio = '{base, base, base};
      end
      // one pause mid-run until every result is back
      queue_pixel(trio[0], trio[1], trio[2], i == 500);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (n_taken < n_pixels || hsv_exp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (n_bad == 0 && hsv_exp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
